### hw/rtl/cpubd_pkg.sv
// Shared types and constants for the console CPU bus decoder.
package cpubd_pkg;

    // Transaction kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // Route codes
    localparam logic [2:0] ROUTE_LOCAL     = 3'd0;
    localparam logic [2:0] ROUTE_PPU_READ  = 3'd1;
    localparam logic [2:0] ROUTE_PPU_WRITE = 3'd2;
    localparam logic [2:0] ROUTE_DMA       = 3'd3;
    localparam logic [2:0] ROUTE_ERROR     = 3'd4;

    // Memory map
    localparam logic [15:0] ADDR_RAM_LAST  = 16'h1FFF;
    localparam logic [15:0] ADDR_PPU_FIRST = 16'h2000;
    localparam logic [15:0] ADDR_PPU_LAST  = 16'h3FFF;
    localparam logic [15:0] ADDR_DMA       = 16'h4014;
    localparam logic [15:0] ADDR_PAD       = 16'h4016;
    localparam logic [15:0] ADDR_ERR_FIRST = 16'h4018;
    localparam logic [15:0] ADDR_ERR_LAST  = 16'h401F;
    localparam logic [15:0] ADDR_PRG_FIRST = 16'h8000;

    // Controller port read pattern (open bus bit)
    localparam logic [7:0] PAD_READ_BASE = 8'h40;

    // Index widths into the mirrored regions
    localparam int RAM_OFS_W = 13;
    localparam int PRG_OFS_W = 15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_INDEX,
        ST_ACCESS,
        ST_FINISH
    } state_t;

endpackage

### hw/rtl/console_cpu_bus_decoder.sv
// Top level: CPU bus decoder with work RAM, program store and controller port.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one bus transaction:
//   kind, address, data_in. Response channel (rsp_valid / rsp_stall)
//   returns one result per transaction: read_data, route,
//   picture_register, picture_write_data, dma_page.
//   A taken request passes the states QUOT, INDEX, ACCESS and FINISH,
//   where the result register is loaded. No new request is taken until
//   the sequencer has walked the transaction through index compute, the
//   memory access and the result load; the memories have one port each.
//   The request side is taken again while an earlier result still waits
//   in the output register; a stalled receiver holds the result and, once
//   the next transaction reaches its last step, holds the request side.
//   Reset: work RAM and program store are zeroed by a clearing pass over
//   max(RAM_DEPTH, PRG_DEPTH) addresses (16384 by default), during which
//   req_stall is high. Controller shift and button latch reset to zero.
//   Program store is loaded by writes to 0x8000-0xFFFF.
module console_cpu_bus_decoder #(
    parameter int RAM_DEPTH = 2048,
    parameter int PRG_DEPTH = 16384
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] kind,
    input  logic [15:0] address,
    input  logic [7:0] data_in,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] read_data,
    output logic [2:0] route,
    output logic [2:0] picture_register,
    output logic [7:0] picture_write_data,
    output logic [7:0] dma_page
);

    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int PRG_AW    = $clog2(PRG_DEPTH);
    localparam int MAX_DEPTH = (RAM_DEPTH > PRG_DEPTH) ? RAM_DEPTH : PRG_DEPTH;
    localparam int CLR_W     = $clog2(MAX_DEPTH) + 1;

    cpubd_pkg::state_t state_reg, state_next;

    logic [1:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]  pad_shift_reg;
    logic [7:0]  button_reg;
    logic        pad_bit_reg;

    logic        rsp_valid_reg, rsp_valid_next;
    logic [7:0]  read_data_reg;
    logic [2:0]  route_reg;
    logic [2:0]  picture_register_reg;
    logic [7:0]  picture_write_data_reg;
    logic [7:0]  dma_page_reg;

    logic        accept;
    logic        do_access;
    logic        load_out;
    logic        clearing;

    logic [RAM_AW-1:0] ram_idx, ram_addr;
    logic [PRG_AW-1:0] prg_idx, prg_addr;
    logic        ram_we, prg_we;
    logic [7:0]  mem_wdata;
    logic [7:0]  ram_rdata, prg_rdata;

    // Decode of the held transaction
    logic is_read, is_write, is_button;
    logic hit_ram, hit_ppu, hit_dma, hit_pad, hit_err, hit_prg;
    logic [2:0] route_val;
    logic [7:0] rd_val;

    assign is_read   = (kind_reg == cpubd_pkg::KIND_READ);
    assign is_write  = (kind_reg == cpubd_pkg::KIND_WRITE);
    assign is_button = (kind_reg == cpubd_pkg::KIND_BUTTON);
    assign hit_ram   = (addr_reg <= cpubd_pkg::ADDR_RAM_LAST);
    assign hit_ppu   = (addr_reg >= cpubd_pkg::ADDR_PPU_FIRST) &&
                       (addr_reg <= cpubd_pkg::ADDR_PPU_LAST);
    assign hit_dma   = (addr_reg == cpubd_pkg::ADDR_DMA);
    assign hit_pad   = (addr_reg == cpubd_pkg::ADDR_PAD);
    assign hit_err   = (addr_reg >= cpubd_pkg::ADDR_ERR_FIRST) &&
                       (addr_reg <= cpubd_pkg::ADDR_ERR_LAST);
    assign hit_prg   = (addr_reg >= cpubd_pkg::ADDR_PRG_FIRST);

    always_comb
    begin
        route_val = cpubd_pkg::ROUTE_LOCAL;
        if (is_read && hit_ppu)
            route_val = cpubd_pkg::ROUTE_PPU_READ;
        else if (is_write && hit_ppu)
            route_val = cpubd_pkg::ROUTE_PPU_WRITE;
        else if (is_write && hit_dma)
            route_val = cpubd_pkg::ROUTE_DMA;
        else if (is_read && hit_err)
            route_val = cpubd_pkg::ROUTE_ERROR;
    end

    always_comb
    begin
        rd_val = 8'd0;
        if (is_read)
        begin
            priority if (hit_ram)
                rd_val = ram_rdata;
            else if (hit_pad)
                rd_val = cpubd_pkg::PAD_READ_BASE | {7'd0, pad_bit_reg};
            else if (hit_prg)
                rd_val = prg_rdata;
            else
                rd_val = 8'd0;
        end
    end

    // Mirror index units
    cpubd_modidx #(
        .DEPTH (RAM_DEPTH),
        .IN_W  (cpubd_pkg::RAM_OFS_W),
        .IDX_W (RAM_AW)
    ) u_ram_idx (
        .clk   (clk),
        .value (addr_reg[cpubd_pkg::RAM_OFS_W-1:0]),
        .index (ram_idx)
    );

    cpubd_modidx #(
        .DEPTH (PRG_DEPTH),
        .IN_W  (cpubd_pkg::PRG_OFS_W),
        .IDX_W (PRG_AW)
    ) u_prg_idx (
        .clk   (clk),
        .value (addr_reg[cpubd_pkg::PRG_OFS_W-1:0]),
        .index (prg_idx)
    );

    // Memories, shared between clearing pass and accesses
    assign clearing  = (state_reg == cpubd_pkg::ST_CLEAR);
    assign ram_addr  = clearing ? clr_cnt_reg[RAM_AW-1:0] : ram_idx;
    assign prg_addr  = clearing ? clr_cnt_reg[PRG_AW-1:0] : prg_idx;
    assign mem_wdata = clearing ? 8'd0 : data_reg;
    assign ram_we    = clearing ? (clr_cnt_reg < CLR_W'(RAM_DEPTH))
                                : (do_access && is_write && hit_ram);
    assign prg_we    = clearing ? (clr_cnt_reg < CLR_W'(PRG_DEPTH))
                                : (do_access && is_write && hit_prg);

    cpubd_ram #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_work_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (mem_wdata),
        .rdata (ram_rdata)
    );

    cpubd_ram #(
        .DEPTH (PRG_DEPTH),
        .AW    (PRG_AW)
    ) u_prg_store (
        .clk   (clk),
        .we    (prg_we),
        .addr  (prg_addr),
        .wdata (mem_wdata),
        .rdata (prg_rdata)
    );

    // Sequencer next state and controls
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        req_stall      = 1'b1;
        do_access      = 1'b0;
        load_out       = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            cpubd_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(MAX_DEPTH - 1))
                    state_next = cpubd_pkg::ST_IDLE;
            end
            cpubd_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                    state_next = cpubd_pkg::ST_QUOT;
            end
            cpubd_pkg::ST_QUOT:
                state_next = cpubd_pkg::ST_INDEX;
            cpubd_pkg::ST_INDEX:
                state_next = cpubd_pkg::ST_ACCESS;
            cpubd_pkg::ST_ACCESS:
            begin
                do_access  = 1'b1;
                state_next = cpubd_pkg::ST_FINISH;
            end
            cpubd_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = cpubd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = cpubd_pkg::ST_IDLE;
        endcase
    end

    assign accept = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpubd_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            pad_shift_reg <= 8'd0;
            button_reg    <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            // Controller port: read shifts, strobe write reloads
            if (do_access)
            begin
                if (is_read && hit_pad)
                    pad_shift_reg <= {1'b0, pad_shift_reg[7:1]};
                else if (is_write && hit_pad && data_reg[0])
                    pad_shift_reg <= button_reg;
                if (is_button)
                    button_reg <= data_reg;
            end
        end
    end

    // Transaction hold and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            addr_reg <= address;
            data_reg <= data_in;
        end
        if (do_access)
            pad_bit_reg <= pad_shift_reg[0];
        if (load_out)
        begin
            read_data_reg          <= rd_val;
            route_reg              <= route_val;
            picture_register_reg   <= (route_val == cpubd_pkg::ROUTE_PPU_READ ||
                                       route_val == cpubd_pkg::ROUTE_PPU_WRITE)
                                      ? addr_reg[2:0] : 3'd0;
            picture_write_data_reg <= (route_val == cpubd_pkg::ROUTE_PPU_WRITE)
                                      ? data_reg : 8'd0;
            dma_page_reg           <= (route_val == cpubd_pkg::ROUTE_DMA)
                                      ? data_reg : 8'd0;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign read_data          = read_data_reg;
    assign route              = route_reg;
    assign picture_register   = picture_register_reg;
    assign picture_write_data = picture_write_data_reg;
    assign dma_page           = dma_page_reg;

endmodule

### hw/rtl/cpubd_ram.sv
// Single-port synchronous byte memory with registered read data.
module cpubd_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Read-first port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cpubd_modidx.sv
// Two-stage offset-modulo-depth unit: reciprocal multiply, then correction.
module cpubd_modidx #(
    parameter int DEPTH  = 2048,
    parameter int IN_W   = 13,
    parameter int IDX_W  = 11
) (
    input  logic             clk,
    input  logic [IN_W-1:0]  value,
    output logic [IDX_W-1:0] index
);

    localparam int L     = $clog2(DEPTH);
    localparam int S     = 2 * IN_W;
    localparam int M_W   = S - L + 2;
    localparam int Q_W   = IN_W - L + 2;
    localparam int P_W   = IN_W + M_W;
    localparam longint unsigned MULT_FULL = (64'd1 << S) / DEPTH;
    localparam logic [M_W-1:0]  MULT      = M_W'(MULT_FULL);
    localparam logic [IN_W:0]   DEPTH_X   = (IN_W + 1)'(DEPTH);

    logic [P_W-1:0]   prod;
    logic [Q_W-1:0]   quot_reg;
    logic [IN_W-1:0]  value_reg;
    logic [IN_W:0]    back;
    logic [IN_W:0]    diff;
    logic [IN_W:0]    rem;
    logic [IDX_W-1:0] index_reg;

    // Quotient estimate, low by at most one
    assign prod = P_W'(value) * P_W'(MULT);

    always_ff @(posedge clk)
    begin
        quot_reg  <= prod[S +: Q_W];
        value_reg <= value;
    end

    // Remainder with one correction step
    assign back = (IN_W + 1)'(quot_reg) * DEPTH_X;
    assign diff = {1'b0, value_reg} - back;
    assign rem  = (diff >= DEPTH_X) ? (diff - DEPTH_X) : diff;

    always_ff @(posedge clk)
    begin
        index_reg <= rem[IDX_W-1:0];
    end

    assign index = index_reg;

endmodule
